/* rtl/q9sf_pkg.sv */
`timescale 1ns / 1ps
// q9sf_pkg: shared widths, node constants and node-to-factor selection
// for the 9-node biquadratic shape function evaluator. no dependencies.
package q9sf_pkg;

  localparam int IN_W       = 18;
  localparam int OUT_W      = 19;
  localparam int SQ_W       = 2 * IN_W;
  localparam int NODE_W     = 4;
  localparam int NODE_COUNT = 9;

  localparam logic [NODE_W-1:0] NODE_FIRST = NODE_W'(0);
  localparam logic [NODE_W-1:0] NODE_LAST  = NODE_W'(NODE_COUNT - 1);

  // which 1-d factor a node uses along one coordinate
  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_CENTRE,
    SEL_PLUS
  } sel_e;

  function automatic sel_e node_u_sel(input logic [NODE_W-1:0] node);
    sel_e s;
    case (node) inside
      4'd0, 4'd3, 4'd7: s = SEL_MINUS;
      4'd1, 4'd2, 4'd5: s = SEL_PLUS;
      4'd4, 4'd6, 4'd8: s = SEL_CENTRE;
      default:          s = SEL_CENTRE;
    endcase
    return s;
  endfunction

  function automatic sel_e node_v_sel(input logic [NODE_W-1:0] node);
    sel_e s;
    case (node) inside
      4'd0, 4'd1, 4'd4: s = SEL_MINUS;
      4'd2, 4'd3, 4'd6: s = SEL_PLUS;
      4'd5, 4'd7, 4'd8: s = SEL_CENTRE;
      default:          s = SEL_CENTRE;
    endcase
    return s;
  endfunction

endpackage

/* rtl/q9sf_factor.sv */
`timescale 1ns / 1ps
// q9sf_factor: 1-d quadratic lagrange factors and their slopes for one
// coordinate, from the coordinate and its square. uses q9sf_pkg.
module q9sf_factor #(
  parameter int FRAC_BITS = 16,
  parameter int FW        = 22
) (
  input  logic signed [q9sf_pkg::IN_W-1:0] c_i,
  input  logic signed [q9sf_pkg::SQ_W-1:0] sq_i,
  output logic signed [FW-1:0]             val_o [3],
  output logic signed [FW-1:0]             der_o [3]
);

  localparam int SqW  = q9sf_pkg::SQ_W;
  localparam int LinW = q9sf_pkg::IN_W + FRAC_BITS + 1;
  localparam int PwA  = (SqW > 2 * FRAC_BITS + 2) ? SqW : 2 * FRAC_BITS + 2;
  localparam int PW   = ((PwA > LinW) ? PwA : LinW) + 1;

  logic signed [PW-1:0] sq_x, lin_x, one_sq, half_hi, half_lo;
  logic signed [PW-1:0] t_minus, t_centre, t_plus;
  logic signed [FW-1:0] c_x, half_f;

  always_comb begin
    sq_x     = PW'(sq_i);
    lin_x    = PW'(c_i) <<< FRAC_BITS;
    one_sq   = PW'(1) <<< (2 * FRAC_BITS);
    half_hi  = PW'(1) <<< FRAC_BITS;
    half_lo  = PW'(1) <<< (FRAC_BITS - 1);
    t_minus  = (sq_x - lin_x + half_hi) >>> (FRAC_BITS + 1);
    t_centre = (one_sq - sq_x + half_lo) >>> FRAC_BITS;
    t_plus   = (sq_x + lin_x + half_hi) >>> (FRAC_BITS + 1);
    val_o[0] = t_minus[FW-1:0];
    val_o[1] = t_centre[FW-1:0];
    val_o[2] = t_plus[FW-1:0];
    c_x      = FW'(c_i);
    half_f   = FW'(1) <<< (FRAC_BITS - 1);
    der_o[0] = c_x - half_f;
    der_o[1] = -(c_x <<< 1);
    der_o[2] = c_x + half_f;
  end

endmodule

/* rtl/quad9_shape_function_eval_unit.sv */
`timescale 1ns / 1ps
// quad9_shape_function_eval_unit: 9-node biquadratic shape values and slopes
// per reference point, four-stage pipeline. uses q9sf_pkg and q9sf_factor.
// a point is taken into the stage 1 register, then the factor register,
// the product register and the output word register; its nine words leave
// in node order, one word per cycle when the output is not stalled, as the
// factor register issues the nine nodes of a point in turn.
// reset clears the valid bits and the node counter only.
module quad9_shape_function_eval_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [q9sf_pkg::IN_W-1:0]     coord_u_i,
  input  logic signed [q9sf_pkg::IN_W-1:0]     coord_v_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [q9sf_pkg::NODE_W-1:0]   node_index_o,
  output logic signed [q9sf_pkg::OUT_W-1:0]    shape_value_o,
  output logic signed [q9sf_pkg::OUT_W-1:0]    slope_u_o,
  output logic signed [q9sf_pkg::OUT_W-1:0]    slope_v_o,
  output logic                                 last_node_o
);

  localparam int InW  = q9sf_pkg::IN_W;
  localparam int SqW  = q9sf_pkg::SQ_W;
  localparam int OutW = q9sf_pkg::OUT_W;
  localparam int NodeW = q9sf_pkg::NODE_W;
  localparam int FwA  = (36 - FRAC_BITS > FRAC_BITS + 2) ? 36 - FRAC_BITS : FRAC_BITS + 2;
  localparam int FW   = ((FwA > 19) ? FwA : 19) + 2;
  localparam int PrW  = 2 * FW;
  localparam int PrLW = PrW + 1;
  localparam logic signed [PrLW-1:0] SatLim = PrLW'(3) <<< FRAC_BITS;

  function automatic logic signed [OutW-1:0] sat_round(input logic signed [PrW-1:0] p);
    logic signed [PrLW-1:0] t;
    t = (PrLW'(p) + (PrLW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > SatLim) begin
      t = SatLim;
    end else if (t < -SatLim) begin
      t = -SatLim;
    end
    return t[OutW-1:0];
  endfunction

  // handshake enables
  logic en1, en2, en3, en4, issue, done2;

  // stage 1: coordinates and squares
  logic                  v1_q;
  logic signed [InW-1:0] u1_q, v1c_q;
  logic signed [SqW-1:0] squ1_q, sqv1_q;

  // stage 2: factor sets, node counter
  logic                  v2_q;
  logic [NodeW-1:0]      cnt_q, cnt_d;
  logic signed [FW-1:0]  uv_d [3], ud_d [3], vv_d [3], vd_d [3];
  logic signed [FW-1:0]  uv_q [3], ud_q [3], vv_q [3], vd_q [3];

  // stage 3: raw products
  q9sf_pkg::sel_e        usel, vsel;
  logic signed [FW-1:0]  a_val, a_der, b_val, b_der;
  logic                  v3_q;
  logic [NodeW-1:0]      node3_q;
  logic signed [PrW-1:0] pv3_q, pu3_q, pw3_q;

  // stage 4: output word
  logic                  v4_q;
  logic [NodeW-1:0]      node4_q;
  logic                  last4_q;
  logic signed [OutW-1:0] val4_q, su4_q, sv4_q;

  always_comb begin
    en4   = !v4_q || !out_stall_i;
    en3   = !v3_q || en4;
    issue = v2_q && en3;
    done2 = issue && (cnt_q == q9sf_pkg::NODE_LAST);
    en2   = !v2_q || done2;
    en1   = !v1_q || en2;
    if (done2) begin
      cnt_d = q9sf_pkg::NODE_FIRST;
    end else if (issue) begin
      cnt_d = cnt_q + NodeW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      cnt_q <= q9sf_pkg::NODE_FIRST;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      u1_q   <= coord_u_i;
      v1c_q  <= coord_v_i;
      squ1_q <= SqW'(coord_u_i) * SqW'(coord_u_i);
      sqv1_q <= SqW'(coord_v_i) * SqW'(coord_v_i);
    end
  end

  q9sf_factor #(
    .FRAC_BITS(FRAC_BITS),
    .FW       (FW)
  ) u_factor_u (
    .c_i  (u1_q),
    .sq_i (squ1_q),
    .val_o(uv_d),
    .der_o(ud_d)
  );

  q9sf_factor #(
    .FRAC_BITS(FRAC_BITS),
    .FW       (FW)
  ) u_factor_v (
    .c_i  (v1c_q),
    .sq_i (sqv1_q),
    .val_o(vv_d),
    .der_o(vd_d)
  );

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      uv_q <= uv_d;
      ud_q <= ud_d;
      vv_q <= vv_d;
      vd_q <= vd_d;
    end
  end

  always_comb begin
    usel = q9sf_pkg::node_u_sel(cnt_q);
    vsel = q9sf_pkg::node_v_sel(cnt_q);
    case (usel)
      q9sf_pkg::SEL_MINUS: begin
        a_val = uv_q[0];
        a_der = ud_q[0];
      end
      q9sf_pkg::SEL_PLUS: begin
        a_val = uv_q[2];
        a_der = ud_q[2];
      end
      default: begin
        a_val = uv_q[1];
        a_der = ud_q[1];
      end
    endcase
    case (vsel)
      q9sf_pkg::SEL_MINUS: begin
        b_val = vv_q[0];
        b_der = vd_q[0];
      end
      q9sf_pkg::SEL_PLUS: begin
        b_val = vv_q[2];
        b_der = vd_q[2];
      end
      default: begin
        b_val = vv_q[1];
        b_der = vd_q[1];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      node3_q <= cnt_q;
      pv3_q   <= PrW'(a_val) * PrW'(b_val);
      pu3_q   <= PrW'(a_der) * PrW'(b_val);
      pw3_q   <= PrW'(a_val) * PrW'(b_der);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      node4_q <= node3_q;
      last4_q <= (node3_q == q9sf_pkg::NODE_LAST);
      val4_q  <= sat_round(pv3_q);
      su4_q   <= sat_round(pu3_q);
      sv4_q   <= sat_round(pw3_q);
    end
  end

  assign out_valid_o   = v4_q;
  assign node_index_o  = node4_q;
  assign last_node_o   = last4_q;
  assign shape_value_o = val4_q;
  assign slope_u_o     = su4_q;
  assign slope_v_o     = sv4_q;

  // node counter only runs while a factor set is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != q9sf_pkg::NODE_FIRST) |-> v2_q)
    else $error("node counter busy without factor set");

  // words of one point leave in node order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_node_o) |=>
      (!out_valid_o || (node_index_o == $past(node_index_o) + NodeW'(1))))
    else $error("node order broken");

  // a taken point lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted point lost");

endmodule
